>>> rtl/core/ghtt_pkg.sv
// shared types and constants for the guest to host id translation table
package ghtt_pkg;

  localparam int TABLE_DEPTH  = 16384;
  localparam int HOST_ID_BITS = 64;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int GID_W        = 32;
  localparam int HID_W        = 64;
  localparam int BATCH_W      = 15;
  localparam int GUARD_W      = 14;
  localparam int MARK_W       = 14;
  localparam int SUM_W        = ((ADDR_W > BATCH_W) ? ADDR_W : BATCH_W) + 1;

  localparam logic [GUARD_W-1:0] GUARD_RESET = GUARD_W'(10000);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_ZERO    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_WALK_RD,
    S_WALK_CHK
  } state_e;

  typedef enum logic [1:0] {
    RD_IN,
    RD_GID,
    RD_MARK
  } rd_sel_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [GID_W-1:0]   src_id;
    logic [HID_W-1:0]   host_id;
    logic [BATCH_W-1:0] batch_count;
  } in_beat_t;

  typedef struct packed {
    logic [HID_W-1:0]  mapped_id;
    logic              present;
    logic [1:0]        status;
    logic [MARK_W-1:0] high_mark;
  } out_beat_t;

  typedef struct packed {
    logic    capture;
    logic    clr_wr;
    logic    exec_wr;
    logic    walk_dec;
    logic    load_out;
    rd_sel_e rd_sel;
  } ghtt_cmd_t;

  typedef struct packed {
    op_e  op;
    logic clr_last;
    logic walk_more;
  } ghtt_sts_t;

endpackage

>>> rtl/core/ghtt_ram.sv
// generic single write port, single read port ram with registered read
module ghtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ghtt_dp.sv
// datapath: input and output registers, guard register, mark, table and checks
module ghtt_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ghtt_pkg::in_beat_t          in_data_i,
  input  logic                        cfg_we_i,
  input  logic [ghtt_pkg::GUARD_W-1:0] cfg_wdata_i,
  input  ghtt_pkg::ghtt_cmd_t         cmd_i,
  output ghtt_pkg::ghtt_sts_t         sts_o,
  output ghtt_pkg::out_beat_t         out_data_o
);
  import ghtt_pkg::*;

  in_beat_t                in_q;
  out_beat_t               out_q;
  out_beat_t               res;
  status_e                 rm_st_q;
  logic [GUARD_W-1:0]      guard_q;
  logic [ADDR_W-1:0]       mark_q, mark_d;
  logic [ADDR_W-1:0]       clr_q, clr_d;
  op_e                     op;
  logic [GID_W-1:0]        gid;
  logic [ADDR_W-1:0]       gid_idx;
  logic                    in_range, known, guard_fail;
  logic [SUM_W-1:0]        sum;
  logic [SUM_W:0]          bound;
  status_e                 ins_st, rm_st;
  logic                    ins_wr, rm_wr;
  logic                    we;
  logic [ADDR_W-1:0]       waddr, raddr;
  logic [HOST_ID_BITS-1:0] wdata, rdata;

  assign op      = op_e'(in_q.op);
  assign gid     = in_q.src_id;
  assign gid_idx = gid[ADDR_W-1:0];

  assign in_range   = gid < GID_W'(TABLE_DEPTH);
  assign known      = !((gid > GID_W'(mark_q)) || (mark_q == '0));
  assign sum        = SUM_W'(mark_q) + SUM_W'(in_q.batch_count);
  assign bound      = {sum, 1'b0};
  assign guard_fail = (gid > GID_W'(bound)) && (gid > GID_W'(guard_q));

  always_comb begin
    if (gid == '0) begin
      ins_st = ST_ZERO;
    end else if (!in_range || guard_fail) begin
      ins_st = ST_REFUSED;
    end else begin
      ins_st = ST_OK;
    end
    if (gid == '0) begin
      rm_st = ST_ZERO;
    end else if (!known) begin
      rm_st = ST_UNKNOWN;
    end else begin
      rm_st = ST_OK;
    end
  end

  assign ins_wr = cmd_i.exec_wr && (op == OP_INSERT) && (ins_st == ST_OK);
  assign rm_wr  = cmd_i.exec_wr && (op == OP_REMOVE) && (rm_st == ST_OK);
  assign we     = cmd_i.clr_wr || ins_wr || rm_wr;
  assign waddr  = cmd_i.clr_wr ? clr_q : gid_idx;
  assign wdata  = (cmd_i.clr_wr || (op == OP_REMOVE)) ? '0 : in_q.host_id[HOST_ID_BITS-1:0];

  always_comb begin
    case (cmd_i.rd_sel)
      RD_IN:   raddr = in_data_i.src_id[ADDR_W-1:0];
      RD_GID:  raddr = gid_idx;
      default: raddr = mark_q;
    endcase
  end

  ghtt_ram #(
    .WIDTH(HOST_ID_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    mark_d = mark_q;
    if (ins_wr && (mark_q < gid_idx)) begin
      mark_d = gid_idx;
    end else if (cmd_i.walk_dec) begin
      mark_d = mark_q - 1'b1;
    end
    clr_d = cmd_i.clr_wr ? clr_q + 1'b1 : clr_q;
  end

  always_comb begin
    res.mapped_id = '0;
    res.present   = 1'b0;
    res.status    = ST_OK;
    res.high_mark = MARK_W'(mark_d);
    case (op)
      OP_INSERT: res.status = ins_st;
      OP_REMOVE: res.status = rm_st_q;
      OP_LOOKUP: begin
        if (known) begin
          res.mapped_id = HID_W'(rdata);
          res.present   = rdata != '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_q <= GUARD_RESET;
      mark_q  <= '0;
      clr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        guard_q <= cfg_wdata_i;
      end
      mark_q <= mark_d;
      clr_q  <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.exec_wr && (op == OP_REMOVE)) begin
      rm_st_q <= rm_st;
    end
    if (cmd_i.load_out) begin
      out_q <= res;
    end
  end

  assign sts_o.op        = op;
  assign sts_o.clr_last  = clr_q == ADDR_W'(TABLE_DEPTH - 1);
  assign sts_o.walk_more = (mark_q != '0) && (rdata == '0);
  assign out_data_o      = out_q;

endmodule

>>> rtl/core/ghtt_ctrl.sv
// controller: clearing pass, per-beat sequencing, mark walk and output valid
module ghtt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  ghtt_pkg::ghtt_sts_t sts_i,
  output ghtt_pkg::ghtt_cmd_t cmd_o
);
  import ghtt_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.rd_sel   = RD_IN;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.rd_sel = RD_GID;
        case (sts_i.op)
          OP_REMOVE: begin
            cmd_o.exec_wr = 1'b1;
            state_d       = S_WALK_RD;
          end
          default: begin
            if (out_free) begin
              cmd_o.exec_wr  = 1'b1;
              cmd_o.load_out = 1'b1;
              state_d        = S_IDLE;
            end
          end
        endcase
      end
      S_WALK_RD: begin
        cmd_o.rd_sel = RD_MARK;
        state_d      = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        cmd_o.rd_sel = RD_MARK;
        if (sts_i.walk_more) begin
          cmd_o.walk_dec = 1'b1;
          state_d        = S_WALK_RD;
        end else if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/guest_host_id_translation_table_top.sv
// top level of the guest to host id translation table
// insert, lookup and unused op: result registered once the output register is free
// remove: after its write the mark walks down past zero entries,
// each step one read of the single table read port and one check
// reset: a clearing pass writes zero to all 16384 table entries, one per cycle,
// with in_stall_o high; the guard register resets to 10000 and the mark to zero
module guest_host_id_translation_table_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ghtt_pkg::in_beat_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ghtt_pkg::out_beat_t          out_data_o,
  input  logic                         cfg_we_i,
  input  logic [ghtt_pkg::GUARD_W-1:0] cfg_wdata_i
);
  import ghtt_pkg::*;

  ghtt_cmd_t cmd;
  ghtt_sts_t sts;

  ghtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ghtt_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

>>> rtl/core/ghtt_checker.sv
// port-level checks for the translation table top, with bind
module ghtt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ghtt_pkg::out_beat_t out_data_o
);
  import ghtt_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // one beat at a time
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while previous beat in flight");

  a_present_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.present |-> out_data_o.mapped_id != '0)
    else $error("present set with zero mapped id");

  a_error_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      !out_data_o.present && (out_data_o.mapped_id == '0))
    else $error("error status with lookup data");

endmodule

bind guest_host_id_translation_table_top ghtt_checker u_checker (.*);
